FILE: rtl/usb_transfer_ring_engine_defines.svh
// Assertion helpers for the checker file.
`ifndef USB_TRANSFER_RING_ENGINE_DEFINES_SVH
`define USB_TRANSFER_RING_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define UTRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define UTRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/utre_pkg.sv
package utre_pkg;

  localparam int ENTRIES_W = 13;
  localparam int LEN_W     = 17;
  localparam int TD_W      = 5;

  typedef enum logic [1:0] {
    FUNC_NORMAL  = 2'd0,
    FUNC_CONTROL = 2'd1,
    FUNC_LINK    = 2'd2,
    FUNC_DEQUEUE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2,
    RES_OFF   = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    DK_NORMAL = 3'd0,
    DK_SETUP  = 3'd1,
    DK_DATA   = 3'd2,
    DK_STATUS = 3'd3,
    DK_LINK   = 3'd4
  } desc_kind_e;

  typedef enum logic [1:0] {
    REG_RING_ENTRIES = 2'd0,
    REG_RING_BASE    = 2'd1,
    REG_RING_ENABLE  = 2'd2
  } reg_idx_e;

  // descriptor type codes, control word bits 15:10
  localparam logic [5:0] TRB_NORMAL = 6'd1;
  localparam logic [5:0] TRB_SETUP  = 6'd2;
  localparam logic [5:0] TRB_DATA   = 6'd3;
  localparam logic [5:0] TRB_STATUS = 6'd4;
  localparam logic [5:0] TRB_LINK   = 6'd6;

  localparam logic [31:0] CTL_CHAIN = 32'h0000_0010;
  localparam logic [31:0] CTL_IOC   = 32'h0000_0020;
  localparam logic [31:0] CTL_IDT   = 32'h0000_0040;
  localparam logic [31:0] CTL_DIR   = 32'h0001_0000;

  localparam logic [1:0] TRT_NONE = 2'd0;
  localparam logic [1:0] TRT_OUT  = 2'd2;
  localparam logic [1:0] TRT_IN   = 2'd3;

  localparam logic [31:0] SETUP_LEN = 32'd8;

  typedef struct packed {
    logic [63:0] param;
    logic [31:0] status;
    logic [31:0] control;
  } desc_t;

  typedef struct packed {
    func_e             func;
    logic [63:0]       buffer_address;
    logic              has_data_buffer;
    logic [63:0]       setup_word;
    logic [LEN_W-1:0]  xfer_len;
    logic [TD_W-1:0]   td_remaining;
    logic              want_interrupt;
    logic              immediate_flag;
    logic              direction_in;
  } req_t;

  typedef struct packed {
    logic [ENTRIES_W-1:0] ring_entries;
    logic [63:0]          ring_base_address;
    logic                 ring_enable;
  } cfg_t;

  function automatic logic [31:0] trb_type(logic [5:0] code);
    return {16'd0, code, 10'd0};
  endfunction

endpackage

FILE: rtl/usb_transfer_ring_engine.sv
// Transfer ring engine: one ring of 128-bit descriptors (64-bit parameter,
// 32-bit status, 32-bit control) kept in a single RAM, with enqueue and
// dequeue indices and producer/consumer cycle bits. Each input item is one
// request, selected by tuser: normal transfer (one descriptor), control
// transfer (setup, optional data, status), link descriptor pointing at
// ring_base_address, or dequeue (returns the next descriptor if its cycle bit
// matches). Every request gets exactly one result item with a result code.
// A full ring holds size-1 descriptors, size being ring_entries clamped into
// 1..RING_DEPTH; a control transfer that fills the ring partway keeps what it
// wrote. Timing: one item at a time; a normal, link or control item passes
// the push state once per descriptor (one RAM write per descriptor, fewer
// when the ring fills), a dequeue the dequeue check, an item with the ring
// off neither; each then reaches the hand-off state, which registers the
// result and returns to idle. A dequeue takes the entry from the registered
// RAM read. While a result waits in the output register, one more item is
// taken and worked, then holds in the hand-off state until the output
// frees up. After reset the RAM is swept to zero, one entry per cycle;
// no item is accepted during the sweep, register writes are.
module usb_transfer_ring_engine #(
  parameter int RING_DEPTH = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB-style configuration port, registers at byte addresses 0, 8, 16
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  // request stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata from bit 0: buffer_address[63:0], has_data_buffer[64],
  // setup_word[128:65], length[145:129], td_remaining[150:146],
  // want_interrupt[151], immediate_flag[152], direction_in[153], zero fill
  input  logic [159:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]    s_axis_tuser,
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata from bit 0: result_code[1:0], entries_written[3:2],
  // out_parameter[67:4], out_status_word[99:68], out_control_word[131:100],
  // zero fill
  output logic [135:0]  m_axis_tdata
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CW     = IDX_W + 1;
  localparam int EW     = (CW > utre_pkg::ENTRIES_W) ? CW : utre_pkg::ENTRIES_W;
  localparam int DESC_W = $bits(utre_pkg::desc_t);

  // sweep, idle, enqueue one descriptor per cycle, dequeue check, result hand-off
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PUSH  = 5'b00100,
    ST_DEQ   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  utre_pkg::cfg_t       cfg;
  state_e               state_q, state_d;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic [IDX_W-1:0]     wr_q, wr_d;
  logic [IDX_W-1:0]     rd_q, rd_d;
  logic                 pc_q, pc_d;
  logic                 cc_q, cc_d;
  utre_pkg::desc_kind_e kind_q, kind_d;
  logic                 m_valid_q, m_valid_d;

  utre_pkg::req_t       req_q, req_d, req_in;
  utre_pkg::res_e       code_q, code_d;
  logic [1:0]           written_q, written_d;
  utre_pkg::desc_t      rdesc_q, rdesc_d;
  logic [135:0]         out_q, out_d;

  logic [CW-1:0]        slots_used;
  logic [IDX_W-1:0]     wr_next, rd_next;
  utre_pkg::desc_t      push_desc, ram_rdata;
  logic [DESC_W-1:0]    ram_rdata_raw;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DESC_W-1:0]    ram_wdata;

  // next index round the ring; anything at or past the size wraps to zero
  function automatic logic [IDX_W-1:0] ring_adv(logic [IDX_W-1:0] idx,
                                                logic [CW-1:0] sz);
    logic [CW-1:0] n;
    n = {1'b0, idx} + CW'(1);
    return (n >= sz) ? '0 : n[IDX_W-1:0];
  endfunction

  utre_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  utre_desc u_desc (
    .kind_i  (kind_q),
    .req_i   (req_q),
    .base_i  (cfg.ring_base_address),
    .cycle_i (pc_q),
    .desc_o  (push_desc)
  );

  // descriptor store; read port always points at the dequeue index so the
  // entry is ready the cycle after a dequeue is accepted
  utre_ram #(
    .WIDTH (DESC_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = utre_pkg::desc_t'(ram_rdata_raw);

  // ring size in use: ring_entries clamped into 1..RING_DEPTH
  always_comb begin
    if (cfg.ring_entries == '0) begin
      slots_used = CW'(1);
    end else if (EW'(cfg.ring_entries) > EW'(RING_DEPTH)) begin
      slots_used = CW'(RING_DEPTH);
    end else begin
      slots_used = CW'(cfg.ring_entries);
    end
  end

  assign wr_next = ring_adv(wr_q, slots_used);
  assign rd_next = ring_adv(rd_q, slots_used);

  // unpack request
  always_comb begin
    req_in.func            = utre_pkg::func_e'(s_axis_tuser);
    req_in.buffer_address  = s_axis_tdata[63:0];
    req_in.has_data_buffer = s_axis_tdata[64];
    req_in.setup_word      = s_axis_tdata[128:65];
    req_in.xfer_len        = s_axis_tdata[145:129];
    req_in.td_remaining    = s_axis_tdata[150:146];
    req_in.want_interrupt  = s_axis_tdata[151];
    req_in.immediate_flag  = s_axis_tdata[152];
    req_in.direction_in    = s_axis_tdata[153];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    pc_d      = pc_q;
    cc_d      = cc_q;
    kind_d    = kind_q;
    m_valid_d = m_valid_q;
    req_d     = req_q;
    code_d    = code_q;
    written_d = written_q;
    rdesc_d   = rdesc_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = wr_q;
    ram_wdata = push_desc;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d     = req_in;
          code_d    = utre_pkg::RES_OK;
          written_d = '0;
          rdesc_d   = '0;
          if (!cfg.ring_enable) begin
            code_d  = utre_pkg::RES_OFF;
            state_d = ST_DONE;
          end else begin
            case (req_in.func)
              utre_pkg::FUNC_NORMAL: begin
                kind_d  = utre_pkg::DK_NORMAL;
                state_d = ST_PUSH;
              end
              utre_pkg::FUNC_CONTROL: begin
                kind_d  = utre_pkg::DK_SETUP;
                state_d = ST_PUSH;
              end
              utre_pkg::FUNC_LINK: begin
                kind_d  = utre_pkg::DK_LINK;
                state_d = ST_PUSH;
              end
              utre_pkg::FUNC_DEQUEUE: state_d = ST_DEQ;
              default:                state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_PUSH: begin
        // one slot always stays free: refuse when the next index meets dequeue
        if (wr_next == rd_q) begin
          code_d  = utre_pkg::RES_FULL;
          state_d = ST_DONE;
        end else begin
          ram_we    = 1'b1;
          wr_d      = wr_next;
          written_d = written_q + 2'd1;
          if (wr_next == '0) begin
            pc_d = ~pc_q;
          end
          case (kind_q)
            utre_pkg::DK_SETUP: begin
              if (req_q.has_data_buffer && (req_q.xfer_len != '0)) begin
                kind_d = utre_pkg::DK_DATA;
              end else begin
                kind_d = utre_pkg::DK_STATUS;
              end
            end
            utre_pkg::DK_DATA: kind_d = utre_pkg::DK_STATUS;
            default:           state_d = ST_DONE;
          endcase
        end
      end
      ST_DEQ: begin
        // empty, or the entry was not produced in the current lap
        if ((rd_q == wr_q) || (ram_rdata.control[0] != cc_q)) begin
          code_d = utre_pkg::RES_EMPTY;
        end else begin
          rdesc_d = ram_rdata;
          rd_d    = rd_next;
          if (rd_next == '0) begin
            cc_d = ~cc_q;
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_d     = {4'd0, rdesc_q.control, rdesc_q.status, rdesc_q.param,
                       written_q, code_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      wr_q      <= '0;
      rd_q      <= '0;
      pc_q      <= 1'b1;
      cc_q      <= 1'b1;
      kind_q    <= utre_pkg::DK_NORMAL;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      pc_q      <= pc_d;
      cc_q      <= cc_d;
      kind_q    <= kind_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    code_q    <= code_d;
    written_q <= written_d;
    rdesc_q   <= rdesc_d;
    out_q     <= out_d;
  end

endmodule

FILE: rtl/utre_ram.sv
module utre_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/utre_regs.sv
module utre_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output utre_pkg::cfg_t      cfg_o
);

  utre_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        utre_pkg::REG_RING_ENTRIES: cfg_d.ring_entries = pwdata[utre_pkg::ENTRIES_W-1:0];
        utre_pkg::REG_RING_BASE:    cfg_d.ring_base_address = pwdata;
        utre_pkg::REG_RING_ENABLE:  cfg_d.ring_enable = pwdata[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      utre_pkg::REG_RING_ENTRIES: prdata = {51'd0, cfg_q.ring_entries};
      utre_pkg::REG_RING_BASE:    prdata = cfg_q.ring_base_address;
      utre_pkg::REG_RING_ENABLE:  prdata = {63'd0, cfg_q.ring_enable};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_entries      <= 13'd4096;
      cfg_q.ring_base_address <= '0;
      cfg_q.ring_enable       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/utre_desc.sv
module utre_desc (
  input  utre_pkg::desc_kind_e kind_i,
  input  utre_pkg::req_t       req_i,
  input  logic [63:0]          base_i,
  input  logic                 cycle_i,
  output utre_pkg::desc_t      desc_o
);

  utre_pkg::desc_t d;
  logic            has_len;
  logic [1:0]      trt;

  assign has_len = (req_i.xfer_len != '0);

  always_comb begin
    if (!has_len) begin
      trt = utre_pkg::TRT_NONE;
    end else if (req_i.direction_in) begin
      trt = utre_pkg::TRT_IN;
    end else begin
      trt = utre_pkg::TRT_OUT;
    end
  end

  always_comb begin
    d = '0;
    case (kind_i)
      utre_pkg::DK_NORMAL: begin
        d.param   = req_i.buffer_address;
        d.status  = {10'd0, req_i.td_remaining, req_i.xfer_len};
        d.control = utre_pkg::trb_type(utre_pkg::TRB_NORMAL)
                  | (req_i.want_interrupt ? utre_pkg::CTL_IOC : 32'd0)
                  | (req_i.immediate_flag ? utre_pkg::CTL_IDT : 32'd0);
      end
      utre_pkg::DK_SETUP: begin
        d.param   = req_i.setup_word;
        d.status  = utre_pkg::SETUP_LEN;
        d.control = utre_pkg::trb_type(utre_pkg::TRB_SETUP) | utre_pkg::CTL_IDT
                  | {14'd0, trt, 16'd0};
      end
      utre_pkg::DK_DATA: begin
        d.param   = req_i.buffer_address;
        d.status  = {15'd0, req_i.xfer_len};
        d.control = utre_pkg::trb_type(utre_pkg::TRB_DATA)
                  | (req_i.direction_in ? utre_pkg::CTL_DIR : 32'd0);
      end
      utre_pkg::DK_STATUS: begin
        // direction bit is set for OUT or no-data transfers
        d.control = utre_pkg::trb_type(utre_pkg::TRB_STATUS) | utre_pkg::CTL_IOC
                  | ((!has_len || !req_i.direction_in) ? utre_pkg::CTL_DIR : 32'd0);
      end
      utre_pkg::DK_LINK: begin
        d.param   = base_i;
        d.control = utre_pkg::trb_type(utre_pkg::TRB_LINK) | utre_pkg::CTL_CHAIN;
      end
      default: d = '0;
    endcase
    d.control[0] = cycle_i;
  end

  assign desc_o = d;

endmodule

FILE: rtl/utre_checker.sv
`include "usb_transfer_ring_engine_defines.svh"

module utre_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  logic [1:0] code;
  logic [1:0] written;
  logic       words_zero;

  assign code       = m_axis_tdata[1:0];
  assign written    = m_axis_tdata[3:2];
  assign words_zero = (m_axis_tdata[131:4] == '0);

  `UTRE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `UTRE_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in work")
  `UTRE_ASSERT_NOW(a_fail_no_words, m_axis_tvalid && (code != utre_pkg::RES_OK), words_zero, "failed request returned descriptor data")
  `UTRE_ASSERT_NOW(a_full_partial, m_axis_tvalid && (code == utre_pkg::RES_FULL), written != 2'd3, "full ring reported with three descriptors written")
  `UTRE_ASSERT_NOW(a_idle_no_write, m_axis_tvalid && ((code == utre_pkg::RES_OFF) || (code == utre_pkg::RES_EMPTY)), written == 2'd0, "descriptors counted on a request that writes none")

endmodule

bind usb_transfer_ring_engine utre_checker u_utre_checker (.*);

FILE: dv/usb_transfer_ring_engine_test.sv
module usb_transfer_ring_engine_test;
  import utre_pkg::*;

  localparam int RING_DEPTH      = 4096;
  localparam int RANDOM_ITEMS    = 1550;
  // Generous ceiling: RAM sweep after reset, ~1600 items with sender gaps,
  // receiver stalls, the long hold-off and the idle pauses around writes.
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Pause that outlasts accept-to-result when nothing stalls.
  localparam int SETTLE_CYCLES   = 12;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Descriptor type fields, control word bits 15:10.
  localparam logic [31:0] NORMAL_TYPE = 32'(TRB_NORMAL) << 10;
  localparam logic [31:0] SETUP_TYPE  = 32'(TRB_SETUP) << 10;
  localparam logic [31:0] DATA_TYPE   = 32'(TRB_DATA) << 10;
  localparam logic [31:0] STATUS_TYPE = 32'(TRB_STATUS) << 10;
  localparam logic [31:0] LINK_TYPE   = 32'(TRB_LINK) << 10;
  // Setup stage transfer type, bits 17:16.
  localparam logic [31:0] SETUP_TRT_IN  = {14'd0, TRT_IN, 16'd0};
  localparam logic [31:0] SETUP_TRT_OUT = {14'd0, TRT_OUT, 16'd0};

  typedef struct packed {
    res_e        code;
    logic [1:0]  written;
    logic [63:0] param;
    logic [31:0] status;
    logic [31:0] control;
  } ring_outcome_t;

  // One row of the directed plan: either a register setting or a request.
  // A request row may carry a hand-written outcome instead of a predicted one.
  typedef struct {
    bit            is_cfg;
    cfg_t          cfg;
    req_t          req;
    bit            fixed;
    ring_outcome_t want;
  } plan_row_t;

  // What the sender offered, in offer order; popped when accepted.
  typedef struct {
    req_t          req;
    bit            fixed;
    ring_outcome_t want;
  } offered_t;

  logic          clk_i;
  logic          rst_ni;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [4:0]    paddr;
  logic [63:0]   pwdata;
  logic [63:0]   prdata;
  logic          pready;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // buffer_address, has_data_buffer, setup_word, length,
  // td_remaining, want_interrupt, immediate_flag, direction_in, zero fill
  logic [159:0]  s_axis_tdata;
  // func
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // result_code, entries_written, out_parameter, out_status_word,
  // out_control_word, zero fill
  logic [135:0]  m_axis_tdata;

  usb_transfer_ring_engine #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------------------------------------------------------------
  // Shadow ring: descriptor slots, indices, cycle bits and registers
  // ---------------------------------------------------------------------
  logic [63:0]   slot_param   [RING_DEPTH];
  logic [31:0]   slot_status  [RING_DEPTH];
  logic [31:0]   slot_control [RING_DEPTH];
  int unsigned   enq_idx;
  int unsigned   deq_idx;
  logic          prod_cycle;
  logic          cons_cycle;
  cfg_t          shadow_cfg;

  ring_outcome_t outcomes_due[$];
  offered_t      offered[$];
  plan_row_t     plan[$];

  int            errors;
  int            cycles;
  int            burst_left;
  bit            hold_requested;
  bit            hold_done;

  // Slots in use: ring_entries clamped into 1..RING_DEPTH.
  function automatic int unsigned slots_used();
    int unsigned s;
    s = shadow_cfg.ring_entries;
    if (s < 1) s = 1;
    if (s > RING_DEPTH) s = RING_DEPTH;
    return s;
  endfunction

  // Index step; an index already past a shrunken size falls back to 0.
  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= slots_used()) ? 0 : idx + 1;
  endfunction

  // Enqueue one descriptor, stamping the producer cycle bit. 0 when full.
  function automatic bit ring_push(logic [63:0] p, logic [31:0] st, logic [31:0] ctl);
    int unsigned nxt;
    int unsigned slot;
    nxt  = ring_next(enq_idx);
    slot = enq_idx % RING_DEPTH;
    if (nxt == deq_idx) return 1'b0;
    slot_param[slot]   = p;
    slot_status[slot]  = st;
    slot_control[slot] = {ctl[31:1], prod_cycle};
    enq_idx = nxt;
    if (enq_idx == 0) prod_cycle = ~prod_cycle;
    return 1'b1;
  endfunction

  // Applies one request to the shadow ring and returns its outcome.
  function automatic ring_outcome_t ring_outcome(req_t r);
    ring_outcome_t res;
    logic [31:0]   ctl;
    bit            ok;
    int unsigned   slot;
    res      = '0;
    res.code = RES_OK;
    if (!shadow_cfg.ring_enable) begin
      res.code = RES_OFF;
    end else begin
      case (r.func)
        FUNC_NORMAL: begin
          ctl = NORMAL_TYPE | (r.want_interrupt ? CTL_IOC : 32'd0)
                | (r.immediate_flag ? CTL_IDT : 32'd0);
          if (ring_push(r.buffer_address, {10'd0, r.td_remaining, r.xfer_len}, ctl))
            res.written = 2'd1;
          else
            res.code = RES_FULL;
        end
        FUNC_CONTROL: begin
          // setup, then data only with a buffer and a length, then status;
          // whatever got in before the ring filled stays
          ctl = SETUP_TYPE | CTL_IDT;
          if (r.xfer_len != 0) ctl |= r.direction_in ? SETUP_TRT_IN : SETUP_TRT_OUT;
          ok = ring_push(r.setup_word, SETUP_LEN, ctl);
          if (ok) res.written = res.written + 2'd1;
          if (ok && r.has_data_buffer && r.xfer_len != 0) begin
            ctl = DATA_TYPE | (r.direction_in ? CTL_DIR : 32'd0);
            ok = ring_push(r.buffer_address, {15'd0, r.xfer_len}, ctl);
            if (ok) res.written = res.written + 2'd1;
          end
          if (ok) begin
            ctl = STATUS_TYPE | CTL_IOC
                  | ((r.xfer_len == 0 || !r.direction_in) ? CTL_DIR : 32'd0);
            ok = ring_push(64'd0, 32'd0, ctl);
            if (ok) res.written = res.written + 2'd1;
          end
          if (!ok) res.code = RES_FULL;
        end
        FUNC_LINK: begin
          if (ring_push(shadow_cfg.ring_base_address, 32'd0, LINK_TYPE | CTL_CHAIN))
            res.written = 2'd1;
          else
            res.code = RES_FULL;
        end
        default: begin
          // empty ring or a slot left over from an older lap
          slot = deq_idx % RING_DEPTH;
          if (deq_idx == enq_idx || slot_control[slot][0] != cons_cycle) begin
            res.code = RES_EMPTY;
          end else begin
            res.param   = slot_param[slot];
            res.status  = slot_status[slot];
            res.control = slot_control[slot];
            deq_idx = ring_next(deq_idx);
            if (deq_idx == 0) cons_cycle = ~cons_cycle;
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic req_t mk_req(func_e f, logic [63:0] buf_addr, logic has_buf,
                                  logic [63:0] setup, logic [LEN_W-1:0] len,
                                  logic [TD_W-1:0] td, logic ioc, logic idt, logic dir);
    req_t r;
    r.func            = f;
    r.buffer_address  = buf_addr;
    r.has_data_buffer = has_buf;
    r.setup_word      = setup;
    r.xfer_len        = len;
    r.td_remaining    = td;
    r.want_interrupt  = ioc;
    r.immediate_flag  = idt;
    r.direction_in    = dir;
    return r;
  endfunction

  // Request with every field but the function zero.
  function automatic req_t bare_req(func_e f);
    return mk_req(f, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
  endfunction

  // Request with every field at its top value.
  function automatic req_t full_req(func_e f);
    return mk_req(f, ONES, 1'b1, ONES, '1, '1, 1'b1, 1'b1, 1'b1);
  endfunction

  function automatic void plan_req(req_t r, bit fixed, res_e code, logic [1:0] wr);
    plan_row_t row;
    row              = '{default: '0};
    row.req          = r;
    row.fixed        = fixed;
    row.want.code    = code;
    row.want.written = wr;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic [ENTRIES_W-1:0] entries, logic [63:0] base,
                                   logic en);
    plan_row_t row;
    row                      = '{default: '0};
    row.is_cfg               = 1'b1;
    row.cfg.ring_entries     = entries;
    row.cfg.ring_base_address = base;
    row.cfg.ring_enable      = en;
    plan.push_back(row);
  endfunction

  // Random request; enq_pct steers fill versus drain of the ring.
  function automatic req_t random_req(int enq_pct);
    req_t r;
    int   pick;
    if ($urandom_range(0, 99) < enq_pct) begin
      pick = $urandom_range(0, 9);
      r.func = (pick < 5) ? FUNC_NORMAL : (pick < 9) ? FUNC_CONTROL : FUNC_LINK;
    end else begin
      r.func = FUNC_DEQUEUE;
    end
    r.buffer_address  = {$urandom, $urandom};
    r.has_data_buffer = 1'($urandom_range(0, 1));
    r.setup_word      = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1:    r.xfer_len = '0;
      2:       r.xfer_len = '1;
      3:       r.xfer_len = LEN_W'($urandom_range(1, 16));
      default: r.xfer_len = LEN_W'($urandom);
    endcase
    r.td_remaining   = TD_W'($urandom);
    r.want_interrupt = 1'($urandom_range(0, 1));
    r.immediate_flag = 1'($urandom_range(0, 1));
    r.direction_in   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Sender side and APB, driven on the falling edge
  // ---------------------------------------------------------------------
  task automatic send_item(req_t r, bit fixed, ring_outcome_t want);
    int       gap;
    offered_t note;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    note.req   = r;
    note.fixed = fixed;
    note.want  = want;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = r.func;
    s_axis_tdata  = {6'd0, r.direction_in, r.immediate_flag, r.want_interrupt,
                     r.td_remaining, r.xfer_len, r.setup_word,
                     r.has_data_buffer, r.buffer_address};
    offered.push_back(note);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
  endtask

  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers change only with nothing in flight.
  task automatic configure(cfg_t c);
    stop_sending();
    while (outcomes_due.size() != 0 || offered.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    apb_write(REG_RING_ENTRIES, 64'(c.ring_entries));
    apb_write(REG_RING_BASE, c.ring_base_address);
    apb_write(REG_RING_ENABLE, 64'(c.ring_enable));
  endtask

  initial begin
    cfg_t          c;
    ring_outcome_t none;
    int            sent;
    int            phase_len;
    int            enq_pct;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    errors        = 0;
    burst_left    = 0;
    hold_requested = 1'b0;
    none          = '0;

    // shadow state after reset
    for (int i = 0; i < RING_DEPTH; i++) begin
      slot_param[i]   = '0;
      slot_status[i]  = '0;
      slot_control[i] = '0;
    end
    enq_idx    = 0;
    deq_idx    = 0;
    prod_cycle = 1'b1;
    cons_cycle = 1'b1;
    shadow_cfg.ring_entries      = ENTRIES_W'(4096);
    shadow_cfg.ring_base_address = '0;
    shadow_cfg.ring_enable       = 1'b0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed plan. Out of reset the ring is off: every request fails.
    plan_req(full_req(FUNC_NORMAL), 1'b1, RES_OFF, 2'd0);
    plan_req(full_req(FUNC_CONTROL), 1'b1, RES_OFF, 2'd0);
    plan_req(full_req(FUNC_LINK), 1'b1, RES_OFF, 2'd0);
    plan_req(full_req(FUNC_DEQUEUE), 1'b1, RES_OFF, 2'd0);
    // four slots, so three fit; link target all ones
    plan_cfg(13'd4, ONES, 1'b1);
    plan_req(bare_req(FUNC_DEQUEUE), 1'b1, RES_EMPTY, 2'd0);
    plan_req(full_req(FUNC_NORMAL), 1'b1, RES_OK, 2'd1);
    // zero length: setup and status only, even with a buffer
    plan_req(mk_req(FUNC_CONTROL, 64'h0123_4567_89AB_CDEF, 1'b1, 64'h0012_0000_0100_0680,
                    '0, '0, 1'b0, 1'b0, 1'b1), 1'b1, RES_OK, 2'd2);
    plan_req(bare_req(FUNC_NORMAL), 1'b1, RES_FULL, 2'd0);
    repeat (3) plan_req(bare_req(FUNC_DEQUEUE), 1'b0, RES_OK, 2'd0);
    plan_req(bare_req(FUNC_DEQUEUE), 1'b1, RES_EMPTY, 2'd0);
    // three stages across the wrap, then the ring is full again
    plan_req(mk_req(FUNC_CONTROL, ONES, 1'b1, 64'h8000_0000_0000_0001, '1, '0,
                    1'b0, 1'b0, 1'b1), 1'b0, RES_OK, 2'd0);
    plan_req(bare_req(FUNC_LINK), 1'b1, RES_FULL, 2'd0);
    repeat (3) plan_req(bare_req(FUNC_DEQUEUE), 1'b0, RES_OK, 2'd0);
    plan_req(mk_req(FUNC_CONTROL, ONES, 1'b0, 64'h5555_AAAA_5555_AAAA, 17'd5, '0,
                    1'b0, 1'b0, 1'b0), 1'b0, RES_OK, 2'd0);
    // ring fills after the setup stage: partial control transfer
    plan_req(mk_req(FUNC_CONTROL, 64'hFEED_0000_0000_0040, 1'b1, 64'h1, 17'd7, '0,
                    1'b0, 1'b0, 1'b1), 1'b0, RES_OK, 2'd0);
    plan_req(bare_req(FUNC_LINK), 1'b0, RES_OK, 2'd0);
    plan_req(bare_req(FUNC_DEQUEUE), 1'b0, RES_OK, 2'd0);
    // size 0 clamps to 1; indices are now past the size
    plan_cfg(13'd0, '0, 1'b1);
    plan_req(mk_req(FUNC_NORMAL, 64'h1234, 1'b0, '0, 17'd1, 5'd3, 1'b1, 1'b0, 1'b0),
             1'b0, RES_OK, 2'd0);
    plan_req(bare_req(FUNC_DEQUEUE), 1'b0, RES_OK, 2'd0);
    plan_req(mk_req(FUNC_CONTROL, ONES, 1'b1, ONES, 17'd64, '0, 1'b0, 1'b0, 1'b1),
             1'b0, RES_OK, 2'd0);
    // oversized value clamps to the full depth
    plan_cfg(13'h1FFF, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
    plan_req(bare_req(FUNC_LINK), 1'b0, RES_OK, 2'd0);
    repeat (2) plan_req(bare_req(FUNC_DEQUEUE), 1'b0, RES_OK, 2'd0);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) configure(plan[i].cfg);
      else send_item(plan[i].req, plan[i].fixed, plan[i].want);
    end

    // Random phases, each with its own ring setting and fill bias.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       c.ring_entries = '0;
        1:       c.ring_entries = ENTRIES_W'(4096);
        2:       c.ring_entries = ENTRIES_W'($urandom_range(4097, 8191));
        3:       c.ring_entries = ENTRIES_W'($urandom_range(13, 300));
        default: c.ring_entries = ENTRIES_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       c.ring_base_address = '0;
        1:       c.ring_base_address = ONES;
        default: c.ring_base_address = {$urandom, $urandom};
      endcase
      c.ring_enable = ($urandom_range(0, 9) != 0);
      configure(c);
      hold_requested = 1'b1;
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 75;
      endcase
      phase_len = $urandom_range(60, 160);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_item(random_req(enq_pct), 1'b0, none);
        sent++;
      end
    end

    stop_sending();
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: segments of random duty, plus one long hold-off once the
  // random traffic starts so the block backs up into its input.
  // ---------------------------------------------------------------------
  initial begin
    int seg;
    int duty;
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_requested && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end
      seg = $urandom_range(1, 30);
      case ($urandom_range(0, 3))
        0:       duty = 100;
        1:       duty = 70;
        2:       duty = 30;
        default: duty = 90;
      endcase
      repeat (seg) begin
        @(negedge clk_i);
        m_axis_tready = ($urandom_range(0, 99) < duty);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: register shadow, prediction on accept, result check
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    ring_outcome_t want;
    offered_t      note;
    if (rst_ni) begin
      cycles++;
      // results first, so an item accepted this edge cannot mask a stray one
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcomes_due.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected, expected nothing, got %h",
                   $time, m_axis_tdata);
        end else begin
          want = outcomes_due.pop_front();
          compare_field("result_code", 64'(want.code), 64'(m_axis_tdata[1:0]));
          compare_field("entries_written", 64'(want.written), 64'(m_axis_tdata[3:2]));
          compare_field("out_parameter", want.param, m_axis_tdata[67:4]);
          compare_field("out_status_word", 64'(want.status), 64'(m_axis_tdata[99:68]));
          compare_field("out_control_word", 64'(want.control), 64'(m_axis_tdata[131:100]));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:3]))
          REG_RING_ENTRIES: shadow_cfg.ring_entries      = pwdata[ENTRIES_W-1:0];
          REG_RING_BASE:    shadow_cfg.ring_base_address = pwdata;
          REG_RING_ENABLE:  shadow_cfg.ring_enable       = pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        note = offered.pop_front();
        // shadow ring advances on every item, fixed rows included
        want = ring_outcome(note.req);
        if (note.fixed) want = note.want;
        outcomes_due.push_back(want);
      end
    end
  end

  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
